### src/crc_pkg.sv
// shared types and constants of the circle raster canvas
package crc_pkg;

  // request kinds carried in s_tuser
  typedef enum logic [1:0] {
    REQ_DRAW  = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } crc_req_t;

  // configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BG     = 2'd2;

  // shape codes
  localparam logic [7:0] SHAPE_OUTLINE = 8'h63;  // 'c'
  localparam logic [7:0] SHAPE_FILLED  = 8'h43;  // 'C'

  // one pixel in Q12.8
  localparam int ONE_Q8 = 256;

  localparam int MAX_SIDE_DEF = 256;

  // input payload layout in s_tdata
  localparam int CX_LSB   = 8;
  localparam int CY_LSB   = 29;
  localparam int R_LSB    = 50;
  localparam int FILL_LSB = 71;
  localparam int ROW_LSB  = 79;
  localparam int COL_LSB  = 87;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 8;

  // geometry of the circle being drawn, fixed for a whole scan
  typedef struct packed {
    logic signed [20:0] cx;
    logic signed [20:0] cy;
    logic [40:0]        r2;
    logic [40:0]        inner2;
    logic               use_inner;
    logic [7:0]         fill;
  } crc_draw_t;

endpackage

### src/circle_raster_canvas_core.sv
// top level of the circle raster canvas: request control, registers, output item
//
// A byte canvas of MAX_SIDE by MAX_SIDE pixels held in one synchronous RAM.
// Each input item is a request (s_tuser: 0 draw, 1 clear, 2 read) and answers
// with exactly one output item. A clear writes one pixel per cycle over the
// whole canvas. A draw first runs its setup (validity check and the two
// radius squares), then sends one pixel per cycle of the configured rows*cols
// area through a three-stage square-and-compare pipeline, then lets the
// pipeline drain. A draw over an empty area ends after setup. A rejected
// draw or an unused request kind goes straight to its result; a read waits
// for the registered RAM read data. One request is in work at a time; the
// next one is taken as soon as the previous result sits in the output
// register. The canvas has no reset and needs no clearing pass: read only
// pixels that a clear or draw has written. Configuration registers may be
// written only while no request is in work.
module circle_raster_canvas_core #(
  parameter int MAX_SIDE = crc_pkg::MAX_SIDE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // s_tdata from bit 0: shape_kind, center_x, center_y, radius, fill_byte,
  // read_row, read_col, zero pad
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [crc_pkg::IN_TDATA_W-1:0] s_tdata,
  // s_tuser: req_type
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // m_tdata: pixel_byte
  output logic [crc_pkg::OUT_TDATA_W-1:0] m_tdata,
  // m_tuser: status
  output logic [0:0]                     m_tuser,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [8:0]                     cfg_data
);
  import crc_pkg::*;

  localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int LW = (SW > 9) ? SW : 9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SETUP2,
    ST_DRAW,
    ST_DRAIN,
    ST_CLEAR,
    ST_READ,
    ST_FINISH
  } state_t;

  state_t              state;
  logic [8:0]          canvas_width;
  logic [8:0]          canvas_height;
  logic [7:0]          background_byte;
  logic [AW-1:0]       scan_row;
  logic [AW-1:0]       scan_col;
  logic [SW-1:0]       draw_rows;
  logic [SW-1:0]       draw_cols;
  crc_draw_t           geo;
  logic signed [20:0]  radius;
  logic                outline;
  logic                rd_ok;
  logic [7:0]          res_pix;
  logic                res_status;

  logic                accept;
  crc_req_t            req;
  logic [7:0]          in_shape;
  logic signed [20:0]  in_radius;
  logic [7:0]          in_row;
  logic [7:0]          in_col;
  logic                bad_draw;
  logic signed [21:0]  r_in;
  logic signed [21:0]  r_off;
  logic [LW-1:0]       lim_rows;
  logic [LW-1:0]       lim_cols;
  logic                col_last;
  logic                row_last;

  logic                pipe_we;
  logic [2*AW-1:0]     pipe_addr;
  logic [7:0]          pipe_data;
  logic                pipe_busy;
  logic                ram_we;
  logic [2*AW-1:0]     ram_waddr;
  logic [7:0]          ram_wdata;
  logic [2*AW-1:0]     ram_raddr;
  logic [7:0]          ram_rdata;

  // input unpacking
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign req       = crc_req_t'(s_tuser);
  assign in_shape  = s_tdata[7:0];
  assign in_radius = s_tdata[R_LSB +: 21];
  assign in_row    = s_tdata[ROW_LSB +: 8];
  assign in_col    = s_tdata[COL_LSB +: 8];
  assign bad_draw  = (in_radius <= 21'sd0) ||
                     ((in_shape != SHAPE_OUTLINE) && (in_shape != SHAPE_FILLED));

  // radius terms for the setup squares
  assign r_in  = 22'(radius);
  assign r_off = r_in - 22'(ONE_Q8);

  // scan limits: configured area for a draw, whole canvas for a clear
  assign lim_rows = (state == ST_CLEAR) ? LW'(MAX_SIDE) : LW'(draw_rows);
  assign lim_cols = (state == ST_CLEAR) ? LW'(MAX_SIDE) : LW'(draw_cols);
  assign col_last = (LW'(scan_col) + LW'(1)) == lim_cols;
  assign row_last = (LW'(scan_row) + LW'(1)) == lim_rows;

  // control, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      m_tvalid        <= 1'b0;
      scan_row        <= '0;
      scan_col        <= '0;
      canvas_width    <= 9'd256;
      canvas_height   <= 9'd256;
      background_byte <= 8'd32;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH:  canvas_width    <= cfg_data;
          CFG_HEIGHT: canvas_height   <= cfg_data;
          CFG_BG:     background_byte <= cfg_data[7:0];
          default:    ;
        endcase
      end
      // output taken; a finishing request reloads the register instead
      if (m_tvalid && m_tready && (state != ST_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            res_pix    <= 8'd0;
            res_status <= 1'b0;
            geo.cx     <= s_tdata[CX_LSB +: 21];
            geo.cy     <= s_tdata[CY_LSB +: 21];
            geo.fill   <= s_tdata[FILL_LSB +: 8];
            radius     <= in_radius;
            outline    <= (in_shape == SHAPE_OUTLINE);
            rd_ok      <= (32'(in_row) < MAX_SIDE) && (32'(in_col) < MAX_SIDE);
            case (req)
              REQ_DRAW: begin
                if (bad_draw) begin
                  res_status <= 1'b1;
                  state      <= ST_FINISH;
                end else begin
                  state <= ST_SETUP;
                end
              end
              REQ_CLEAR: state <= ST_CLEAR;
              REQ_READ:  state <= ST_READ;
              default:   state <= ST_FINISH;
            endcase
          end
        end
        ST_SETUP: begin
          geo.r2        <= 41'(44'(r_in) * 44'(r_in));
          geo.use_inner <= outline && (radius > 21'sd256);
          draw_rows     <= (LW'(canvas_height) > LW'(MAX_SIDE)) ? SW'(MAX_SIDE)
                                                                : SW'(canvas_height);
          draw_cols     <= (LW'(canvas_width) > LW'(MAX_SIDE)) ? SW'(MAX_SIDE)
                                                               : SW'(canvas_width);
          state         <= ST_SETUP2;
        end
        ST_SETUP2: begin
          geo.inner2 <= 41'(44'(r_off) * 44'(r_off));
          if ((draw_rows == '0) || (draw_cols == '0)) begin
            state <= ST_FINISH;
          end else begin
            state <= ST_DRAW;
          end
        end
        ST_DRAW, ST_CLEAR: begin
          if (col_last) begin
            scan_col <= '0;
            if (row_last) begin
              scan_row <= '0;
              state    <= (state == ST_DRAW) ? ST_DRAIN : ST_FINISH;
            end else begin
              scan_row <= scan_row + AW'(1);
            end
          end else begin
            scan_col <= scan_col + AW'(1);
          end
        end
        ST_DRAIN: begin
          if (!pipe_busy) begin
            state <= ST_FINISH;
          end
        end
        ST_READ: begin
          res_pix <= rd_ok ? ram_rdata : 8'd0;
          state   <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= res_pix;
            m_tuser  <= res_status;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // distance test pipeline
  crc_disk_test #(
    .AW(AW)
  ) u_disk (
    .clk     (clk),
    .rst     (rst),
    .geo     (geo),
    .in_valid(state == ST_DRAW),
    .in_row  (scan_row),
    .in_col  (scan_col),
    .wr_en   (pipe_we),
    .wr_addr (pipe_addr),
    .wr_data (pipe_data),
    .busy    (pipe_busy)
  );

  // canvas write port: clear sweep or pipeline hits
  assign ram_we    = (state == ST_CLEAR) || pipe_we;
  assign ram_waddr = (state == ST_CLEAR) ? {scan_row, scan_col} : pipe_addr;
  assign ram_wdata = (state == ST_CLEAR) ? background_byte : pipe_data;
  assign ram_raddr = {AW'(in_row), AW'(in_col)};

  crc_canvas_ram #(
    .ADDR_W(2 * AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

`ifndef SYNTHESIS
  // scan counters rest at zero between requests
  a_scan_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (scan_row == '0) && (scan_col == '0))
    else $error("scan counters not zero while idle");

  // no canvas write may land while a read is being served
  a_read_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> !ram_we)
    else $error("canvas written during read");

  // a result is only issued after all draw writes have landed
  a_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> !pipe_busy)
    else $error("result issued with draw writes pending");

  // a rejected draw carries a zero pixel
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
    else $error("rejected item with nonzero pixel");
`endif

endmodule

### src/crc_canvas_ram.sv
// canvas storage: one write port, one read port with registered data
module crc_canvas_ram #(
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [(1 << ADDR_W)];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### src/crc_disk_test.sv
// pixel pipeline: offset, square, compare against the ring, emit canvas writes
module crc_disk_test #(
  parameter int AW = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  crc_pkg::crc_draw_t    geo,
  input  logic                  in_valid,
  input  logic [AW-1:0]         in_row,
  input  logic [AW-1:0]         in_col,
  output logic                  wr_en,
  output logic [2*AW-1:0]       wr_addr,
  output logic [7:0]            wr_data,
  output logic                  busy
);
  import crc_pkg::*;

  localparam int DW = ((AW + 9 > 21) ? AW + 9 : 21) + 1;
  localparam int SQW = 2 * DW;

  logic signed [DW-1:0]  pos_x;
  logic signed [DW-1:0]  pos_y;
  logic signed [DW-1:0]  dx;
  logic signed [DW-1:0]  dy;
  logic signed [SQW-1:0] px;
  logic signed [SQW-1:0] py;
  logic [SQW-1:0]        sqx;
  logic [SQW-1:0]        sqy;
  logic [SQW:0]          d2;
  logic                  hit;
  logic                  v1;
  logic                  v2;
  logic [2*AW-1:0]       a1;
  logic [2*AW-1:0]       a2;

  // pixel position scaled to Q.8
  assign pos_x = {{(DW - AW - 8){1'b0}}, in_col, 8'h00};
  assign pos_y = {{(DW - AW - 8){1'b0}}, in_row, 8'h00};

  // squares of the registered offsets
  assign px = dx * dx;
  assign py = dy * dy;

  // ring test on the summed squares
  assign d2  = {1'b0, sqx} + {1'b0, sqy};
  assign hit = (d2 <= (SQW + 1)'(geo.r2)) &&
               !(geo.use_inner && (d2 < (SQW + 1)'(geo.inner2)));

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      wr_en <= 1'b0;
    end else begin
      v1    <= in_valid;
      v2    <= v1;
      wr_en <= v2 && hit;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    dx      <= DW'(geo.cx) - pos_x;
    dy      <= DW'(geo.cy) - pos_y;
    a1      <= {in_row, in_col};
    sqx     <= SQW'(px);
    sqy     <= SQW'(py);
    a2      <= a1;
    wr_addr <= a2;
    wr_data <= geo.fill;
  end

  assign busy = v1 || v2 || wr_en;

endmodule

### tb/circle_raster_canvas_core_tb.sv
// self-checking testbench of the circle raster canvas core: directed table, then random phases
`timescale 1ns / 100ps

module circle_raster_canvas_core_tb;
  import crc_pkg::*;

  localparam int MAX_SIDE = MAX_SIDE_DEF;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int LONG_HOLD = 400;
  localparam int HOLD_AT = 45;
  localparam int PHASES = 7;
  localparam int ITEMS_PER_PHASE = 11;
  localparam int MAX_RANDOM_CLEARS = 4;
  localparam int DRAIN_CYCLES = 16;

  // one request item as the sender sees it
  typedef struct packed {
    crc_req_t           kind;
    logic [7:0]         shape;
    logic signed [20:0] cx;
    logic signed [20:0] cy;
    logic signed [20:0] rad;
    logic [7:0]         fill;
    logic [7:0]         row;
    logic [7:0]         col;
  } canvas_req_t;

  // one result item
  typedef struct packed {
    logic [7:0] pix;
    logic       status;
  } answer_t;

  // directed row: request plus an answer typed in where it is obvious
  typedef struct packed {
    canvas_req_t rq;
    logic        typed;
    answer_t     ans;
  } probe_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [0:0] m_tuser;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;

  // shadow copy of the canvas and its registers
  logic [7:0] shadow_canvas [0:MAX_SIDE*MAX_SIDE-1];
  logic [8:0] cur_width = 9'd256;
  logic [8:0] cur_height = 9'd256;
  logic [7:0] cur_bg = 8'd32;

  answer_t answers [$];
  int errors = 0;
  logic calm = 1'b0;

  // canvas settings of the random phases, -1 picks a random value
  int phase_w [PHASES] = '{1, 0, 511, 4, 256, -1, -1};
  int phase_h [PHASES] = '{1, 9, 2, 300, 3, -1, -1};
  int phase_bg [PHASES] = '{0, -1, 255, -1, -1, -1, -1};

  // directed rows at the reset configuration (256 x 256, background 32)
  probe_t probes [21] = '{
    // rejected draws: zero radius, most negative radius, bad shape bytes
    '{'{REQ_DRAW, SHAPE_FILLED, 21'd2560, 21'd2560, 21'd0, 8'hEE, 8'h00, 8'h00},
      1'b1, '{8'h00, 1'b1}},
    '{'{REQ_DRAW, SHAPE_OUTLINE, 21'd2560, 21'd2560, 21'h100000, 8'hEE, 8'h00, 8'h00},
      1'b1, '{8'h00, 1'b1}},
    '{'{REQ_DRAW, 8'h00, 21'd2560, 21'd2560, 21'd256, 8'hEE, 8'h00, 8'h00},
      1'b1, '{8'h00, 1'b1}},
    '{'{REQ_DRAW, 8'hFF, 21'd2560, 21'd2560, 21'h0FFFFF, 8'hEE, 8'h00, 8'h00},
      1'b1, '{8'h00, 1'b1}},
    // unused request kind with every field at ones
    '{'{REQ_NONE, 8'hFF, 21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 8'hFF, 8'hFF, 8'hFF},
      1'b1, '{8'h00, 1'b0}},
    // clear, then read both corners
    '{'{REQ_CLEAR, 8'h00, 21'd0, 21'd0, 21'd0, 8'h00, 8'h00, 8'h00},
      1'b1, '{8'h00, 1'b0}},
    '{'{REQ_READ, 8'h00, 21'd0, 21'd0, 21'd0, 8'h00, 8'h00, 8'h00},
      1'b1, '{8'd32, 1'b0}},
    '{'{REQ_READ, 8'h00, 21'd0, 21'd0, 21'd0, 8'h00, 8'hFF, 8'hFF},
      1'b1, '{8'd32, 1'b0}},
    // largest radius covers the whole canvas
    '{'{REQ_DRAW, SHAPE_FILLED, 21'd32640, 21'd32640, 21'h0FFFFF, 8'hA5, 8'h00, 8'h00},
      1'b1, '{8'h00, 1'b0}},
    '{'{REQ_READ, 8'h00, 21'd0, 21'd0, 21'd0, 8'h00, 8'hFF, 8'h00},
      1'b1, '{8'hA5, 1'b0}},
    '{'{REQ_CLEAR, SHAPE_OUTLINE, 21'd2560, 21'd2560, 21'd768, 8'h77, 8'h12, 8'h34},
      1'b1, '{8'h00, 1'b0}},
    // filled disc, reads on and just past the rim
    '{'{REQ_DRAW, SHAPE_FILLED, 21'd2560, 21'd2560, 21'd768, 8'hFF, 8'h00, 8'h00},
      1'b1, '{8'h00, 1'b0}},
    '{'{REQ_READ, 8'h00, 21'd0, 21'd0, 21'd0, 8'h00, 8'd10, 8'd13},
      1'b0, '{8'h00, 1'b0}},
    '{'{REQ_READ, 8'h00, 21'd0, 21'd0, 21'd0, 8'h00, 8'd10, 8'd14},
      1'b0, '{8'h00, 1'b0}},
    // outline with fractional center, inside stays background
    '{'{REQ_DRAW, SHAPE_OUTLINE, 21'd25728, 21'd12864, 21'd2688, 8'h11, 8'h00, 8'h00},
      1'b1, '{8'h00, 1'b0}},
    '{'{REQ_READ, 8'h00, 21'd0, 21'd0, 21'd0, 8'h00, 8'd50, 8'd100},
      1'b0, '{8'h00, 1'b0}},
    '{'{REQ_READ, 8'h00, 21'd0, 21'd0, 21'd0, 8'h00, 8'd50, 8'd110},
      1'b0, '{8'h00, 1'b0}},
    // outline of radius exactly one pixel skips nothing
    '{'{REQ_DRAW, SHAPE_OUTLINE, 21'd51200, 21'd51200, 21'd256, 8'h22, 8'h00, 8'h00},
      1'b1, '{8'h00, 1'b0}},
    '{'{REQ_READ, 8'h00, 21'd0, 21'd0, 21'd0, 8'h00, 8'd200, 8'd200},
      1'b0, '{8'h00, 1'b0}},
    // extreme center and radius values
    '{'{REQ_DRAW, SHAPE_OUTLINE, 21'h100000, 21'h0FFFFF, 21'h0FFFFF, 8'h00, 8'h00, 8'h00},
      1'b1, '{8'h00, 1'b0}},
    '{'{REQ_READ, 8'h00, 21'd0, 21'd0, 21'd0, 8'h00, 8'hFF, 8'h00},
      1'b0, '{8'h00, 1'b0}}
  };

  circle_raster_canvas_core #(
    .MAX_SIDE(MAX_SIDE)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // applies one request to the shadow canvas and returns its answer
  function automatic answer_t predict_answer(canvas_req_t rq);
    answer_t a;
    longint cx, cy, rad, r2, inner2, dx, dy, d2;
    int rows, cols, i, j;
    logic ring;
    a = '0;
    case (rq.kind)
      REQ_DRAW: begin
        cx = $signed(rq.cx);
        cy = $signed(rq.cy);
        rad = $signed(rq.rad);
        if (rad <= 0 || (rq.shape != SHAPE_OUTLINE && rq.shape != SHAPE_FILLED)) begin
          a.status = 1'b1;
        end else begin
          // outline drops pixels closer than r - 1, only when r is above one pixel
          ring = (rq.shape == SHAPE_OUTLINE) && (rad > ONE_Q8);
          r2 = rad * rad;
          inner2 = (rad - ONE_Q8) * (rad - ONE_Q8);
          rows = (cur_height > MAX_SIDE) ? MAX_SIDE : int'(cur_height);
          cols = (cur_width > MAX_SIDE) ? MAX_SIDE : int'(cur_width);
          for (i = 0; i < rows; i++) begin
            dy = cy - longint'(i) * ONE_Q8;
            for (j = 0; j < cols; j++) begin
              dx = cx - longint'(j) * ONE_Q8;
              d2 = dx * dx + dy * dy;
              if (d2 <= r2 && !(ring && d2 < inner2)) begin
                shadow_canvas[i * MAX_SIDE + j] = rq.fill;
              end
            end
          end
        end
      end
      REQ_CLEAR: begin
        foreach (shadow_canvas[k]) shadow_canvas[k] = cur_bg;
      end
      REQ_READ: begin
        a.pix = shadow_canvas[{rq.row, rq.col}];
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  // offers one item after a random gap and records its expected answer
  task automatic send_request(canvas_req_t rq, logic typed, answer_t typed_ans);
    int gap;
    answer_t a;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tuser <= rq.kind;
    s_tdata <= IN_TDATA_W'({rq.col, rq.row, rq.fill, rq.rad, rq.cy, rq.cx, rq.shape});
    s_tvalid <= 1'b1;
    do @(posedge clk); while (s_tready !== 1'b1);
    a = predict_answer(rq);
    answers.push_back(typed ? typed_ans : a);
  endtask

  // stops offering and waits until every answer is back
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // writes all three canvas registers back to back
  task automatic program_canvas(logic [8:0] w, logic [8:0] h, logic [7:0] bg);
    cfg_we <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_index <= CFG_BG;
    cfg_data <= {1'b0, bg};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_width = w;
    cur_height = h;
    cur_bg = bg;
  endtask

  // request stream: reset, directed table, random phases
  initial begin : stimulus
    canvas_req_t rq;
    int p, n, roll, rows_eff, cols_eff, rad_top, clears_left, w, h, bg;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (probes[k]) send_request(probes[k].rq, probes[k].typed, probes[k].ans);

    clears_left = MAX_RANDOM_CLEARS;
    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      w = (phase_w[p] < 0) ? $urandom_range(2, 24) : phase_w[p];
      h = (phase_h[p] < 0) ? $urandom_range(2, 24) : phase_h[p];
      bg = (phase_bg[p] < 0) ? $urandom_range(0, 255) : phase_bg[p];
      program_canvas(9'(w), 9'(h), 8'(bg));
      calm = (p % 2 == 1);
      rows_eff = (cur_height > MAX_SIDE) ? MAX_SIDE : int'(cur_height);
      cols_eff = (cur_width > MAX_SIDE) ? MAX_SIDE : int'(cur_width);
      rad_top = ((rows_eff > cols_eff ? rows_eff : cols_eff) / 2 + 2) * ONE_Q8;

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // fields a request does not use carry random bits
        rq.kind = crc_req_t'(2'($urandom));
        rq.shape = 8'($urandom);
        rq.cx = 21'($urandom);
        rq.cy = 21'($urandom);
        rq.rad = 21'($urandom);
        rq.fill = 8'($urandom);
        rq.row = 8'($urandom);
        rq.col = 8'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 3 && clears_left > 0) begin
          clears_left--;
          rq.kind = REQ_CLEAR;
        end else if (roll < 10) begin
          rq.kind = REQ_NONE;
        end else if (roll < 50) begin
          // reads mostly land inside the area in use
          rq.kind = REQ_READ;
          if ($urandom_range(0, 9) < 7 && rows_eff > 0 && cols_eff > 0) begin
            rq.row = 8'($urandom_range(0, rows_eff - 1));
            rq.col = 8'($urandom_range(0, cols_eff - 1));
          end
        end else begin
          rq.kind = REQ_DRAW;
          roll = $urandom_range(0, 19);
          if (roll < 9) begin
            rq.shape = SHAPE_FILLED;
          end else if (roll < 18) begin
            rq.shape = SHAPE_OUTLINE;
          end
          // center near the canvas unless left at full range
          if ($urandom_range(0, 6) != 0) begin
            rq.cx = 21'(int'($urandom_range(0, cols_eff * ONE_Q8 + 255)) - 128);
            rq.cy = 21'(int'($urandom_range(0, rows_eff * ONE_Q8 + 255)) - 128);
          end
          // radius: non-positive, full range, around one pixel, or sized to the canvas
          roll = $urandom_range(0, 19);
          if (roll == 0) begin
            rq.rad = ($urandom_range(0, 1) == 0) ? 21'd0
                                                  : 21'(-int'($urandom_range(1, 1048576)));
          end else if (roll < 3) begin
          end else if (roll < 6) begin
            rq.rad = 21'($urandom_range(1, 2 * ONE_Q8 + 1));
          end else begin
            rq.rad = 21'($urandom_range(1, rad_top));
          end
        end
        send_request(rq, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off, field checks
  initial begin : check_results
    int stall;
    int taken;
    answer_t want;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      stall = (taken == HOLD_AT) ? LONG_HOLD : (calm ? 0 : $urandom_range(0, 4));
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      taken++;
      if (answers.size() == 0) begin
        $display("%0t ns: output item with none expected, got pixel_byte %02h status %0b",
                 $time, m_tdata, m_tuser[0]);
        errors++;
      end else begin
        want = answers.pop_front();
        if (m_tdata !== want.pix) begin
          $display("%0t ns: pixel_byte expected %02h, got %02h", $time, want.pix, m_tdata);
          errors++;
        end
        if (m_tuser[0] !== want.status) begin
          $display("%0t ns: status expected %0b, got %0b", $time, want.status, m_tuser[0]);
          errors++;
        end
      end
    end
  end

  // cycle limit
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

endmodule
